// ===== sv/rmq_pkg.sv =====
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared types and constants for the rotation matrix to quaternion pipeline.
// ----------------------------------------------------------------------------
package rmq_pkg;

  localparam int unsigned Q_W    = 16;  // Q1.14 word
  localparam int unsigned D_W    = 18;  // sum or difference of two words
  localparam int unsigned RAD_W  = 32;  // radicand, arg << 14, padded even
  localparam int unsigned ROOT_W = RAD_W / 2;
  localparam int unsigned REM_W  = ROOT_W + 3;
  localparam int unsigned NUM_W  = 31;  // mag * 16384 + root
  localparam int unsigned DIV_N  = 24;  // quotient bits
  localparam int unsigned DVS_W  = ROOT_W + 1;
  localparam int unsigned LANES  = 4;
  localparam logic signed [18:0] ONE_Q14 = 19'sd16384;

  // quaternion component lanes
  typedef enum logic [1:0] {
    LANE_W = 2'd0,
    LANE_X = 2'd1,
    LANE_Y = 2'd2,
    LANE_Z = 2'd3
  } lane_e;

  typedef logic [8:0][Q_W-1:0]         mat_t;
  typedef logic [LANES-1:0][NUM_W-1:0] num4_t;
  typedef logic [LANES-1:0][DIV_N-1:0] quo4_t;

  // item info carried alongside the square root
  typedef struct packed {
    lane_e                     sel;  // lane that takes the half root
    logic                      bad;
    logic [LANES-1:0][D_W-1:0] d;    // signed numerators per lane
  } side_t;

  // item info carried alongside the divider
  typedef struct packed {
    lane_e             sel;
    logic              bad;
    logic [Q_W-1:0]    hr;   // rounded half root
    logic [LANES-1:0]  neg;
  } dside_t;

endpackage

// ===== sv/rmq_prep.sv =====
// ----------------------------------------------------------------------------
// rmq_prep
// Branch selection, square-root argument and numerators, one register stage.
// ----------------------------------------------------------------------------
module rmq_prep import rmq_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_vld,
  input  mat_t             in_mat,
  output logic             out_vld,
  output logic [RAD_W-1:0] out_rad,
  output side_t            out_side
);

  logic             vld_r, vld_nxt;
  logic [RAD_W-1:0] rad_r, rad_nxt;
  side_t            side_r, side_nxt;

  logic signed [Q_W-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22, mcur;
  logic signed [D_W-1:0] tr;
  logic signed [18:0]    arg;
  logic                  pick1, pick2;

  assign m00 = $signed(in_mat[0]);
  assign m01 = $signed(in_mat[1]);
  assign m02 = $signed(in_mat[2]);
  assign m10 = $signed(in_mat[3]);
  assign m11 = $signed(in_mat[4]);
  assign m12 = $signed(in_mat[5]);
  assign m20 = $signed(in_mat[6]);
  assign m21 = $signed(in_mat[7]);
  assign m22 = $signed(in_mat[8]);

  // trace and largest diagonal, ties keep the lower index
  assign tr    = D_W'(m00) + D_W'(m11) + D_W'(m22);
  assign pick1 = m11 > m00;
  assign mcur  = pick1 ? m11 : m00;
  assign pick2 = m22 > mcur;

  always_comb begin
    side_nxt = '0;
    arg      = '0;
    priority if (tr > 0) begin
      side_nxt.sel     = LANE_W;
      arg              = 19'(tr) + ONE_Q14;
      side_nxt.d[LANE_X] = D_W'(m21) - D_W'(m12);
      side_nxt.d[LANE_Y] = D_W'(m02) - D_W'(m20);
      side_nxt.d[LANE_Z] = D_W'(m10) - D_W'(m01);
    end else if (pick2) begin
      side_nxt.sel     = LANE_Z;
      arg              = 19'(m22) - 19'(m00) - 19'(m11) + ONE_Q14;
      side_nxt.d[LANE_W] = D_W'(m10) - D_W'(m01);
      side_nxt.d[LANE_X] = D_W'(m02) + D_W'(m20);
      side_nxt.d[LANE_Y] = D_W'(m12) + D_W'(m21);
    end else if (pick1) begin
      side_nxt.sel     = LANE_Y;
      arg              = 19'(m11) - 19'(m22) - 19'(m00) + ONE_Q14;
      side_nxt.d[LANE_W] = D_W'(m02) - D_W'(m20);
      side_nxt.d[LANE_Z] = D_W'(m21) + D_W'(m12);
      side_nxt.d[LANE_X] = D_W'(m01) + D_W'(m10);
    end else begin
      side_nxt.sel     = LANE_X;
      arg              = 19'(m00) - 19'(m11) - 19'(m22) + ONE_Q14;
      side_nxt.d[LANE_W] = D_W'(m21) - D_W'(m12);
      side_nxt.d[LANE_Y] = D_W'(m10) + D_W'(m01);
      side_nxt.d[LANE_Z] = D_W'(m20) + D_W'(m02);
    end
    side_nxt.bad = (arg <= 0);
    rad_nxt      = side_nxt.bad ? '0 : {1'b0, arg[16:0], 14'b0};
    vld_nxt      = in_vld;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
    if (en) begin
      rad_r  <= rad_nxt;
      side_r <= side_nxt;
    end
  end

  assign out_vld  = vld_r;
  assign out_rad  = rad_r;
  assign out_side = side_r;

endmodule

// ===== sv/rmq_isqrt.sv =====
// ----------------------------------------------------------------------------
// rmq_isqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module rmq_isqrt import rmq_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_vld,
  input  logic [RAD_W-1:0]  in_rad,
  input  side_t             in_side,
  output logic              out_vld,
  output logic [ROOT_W-1:0] out_root,
  output side_t             out_side
);

  logic              vld_r  [ROOT_W];
  logic [RAD_W-1:0]  rad_r  [ROOT_W];
  logic [REM_W-1:0]  rem_r  [ROOT_W];
  logic [ROOT_W-1:0] root_r [ROOT_W];
  side_t             side_r [ROOT_W];

  logic              vld_nxt  [ROOT_W];
  logic [RAD_W-1:0]  rad_nxt  [ROOT_W];
  logic [REM_W-1:0]  rem_nxt  [ROOT_W];
  logic [ROOT_W-1:0] root_nxt [ROOT_W];
  side_t             side_nxt [ROOT_W];

  // one digit step per stage
  always_comb begin
    logic [RAD_W-1:0]  rad_i;
    logic [REM_W-1:0]  rem_i, rem2, trial;
    logic [ROOT_W-1:0] root_i;
    logic              ge;
    for (int k = 0; k < ROOT_W; k++) begin
      if (k == 0) begin
        rad_i = in_rad; rem_i = '0; root_i = '0;
        vld_nxt[k] = in_vld; side_nxt[k] = in_side;
      end else begin
        rad_i = rad_r[k-1]; rem_i = rem_r[k-1]; root_i = root_r[k-1];
        vld_nxt[k] = vld_r[k-1]; side_nxt[k] = side_r[k-1];
      end
      rem2  = {rem_i[REM_W-3:0], rad_i[RAD_W-1 -: 2]};
      trial = {1'b0, root_i, 2'b01};
      ge    = rem2 >= trial;
      rem_nxt[k]  = ge ? rem2 - trial : rem2;
      root_nxt[k] = {root_i[ROOT_W-2:0], ge};
      rad_nxt[k]  = {rad_i[RAD_W-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < ROOT_W; k++) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_nxt[k];
      end
      if (en) begin
        rad_r[k]  <= rad_nxt[k];
        rem_r[k]  <= rem_nxt[k];
        root_r[k] <= root_nxt[k];
        side_r[k] <= side_nxt[k];
      end
    end
  end

  assign out_vld  = vld_r[ROOT_W-1];
  assign out_root = root_r[ROOT_W-1];
  assign out_side = side_r[ROOT_W-1];

endmodule

// ===== sv/rmq_div.sv =====
// ----------------------------------------------------------------------------
// rmq_div
// Four-lane pipelined restoring divider sharing one divisor, bit per stage.
// ----------------------------------------------------------------------------
module rmq_div import rmq_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_vld,
  input  num4_t            in_num,
  input  logic [DVS_W-1:0] in_dvs,
  input  dside_t           in_side,
  output logic             out_vld,
  output quo4_t            out_quo,
  output dside_t           out_side
);

  logic                                vld_r [DIV_N];
  logic [DVS_W-1:0]                    dvs_r [DIV_N];
  logic [LANES-1:0][DVS_W-1:0]         rem_r [DIV_N];
  quo4_t                               num_r [DIV_N];
  dside_t                              side_r [DIV_N];

  logic                                vld_nxt [DIV_N];
  logic [DVS_W-1:0]                    dvs_nxt [DIV_N];
  logic [LANES-1:0][DVS_W-1:0]         rem_nxt [DIV_N];
  quo4_t                               num_nxt [DIV_N];
  dside_t                              side_nxt [DIV_N];

  // numerator bits shift out the top, quotient bits shift in the bottom
  always_comb begin
    logic [LANES-1:0][DVS_W-1:0] rem_i;
    quo4_t                       num_i;
    logic [DVS_W:0]              rem2;
    logic                        ge;
    for (int k = 0; k < DIV_N; k++) begin
      if (k == 0) begin
        for (int l = 0; l < LANES; l++) begin
          rem_i[l] = DVS_W'(in_num[l][NUM_W-1:DIV_N]);
          num_i[l] = in_num[l][DIV_N-1:0];
        end
        dvs_nxt[k] = in_dvs; vld_nxt[k] = in_vld; side_nxt[k] = in_side;
      end else begin
        rem_i = rem_r[k-1]; num_i = num_r[k-1];
        dvs_nxt[k] = dvs_r[k-1]; vld_nxt[k] = vld_r[k-1];
        side_nxt[k] = side_r[k-1];
      end
      for (int l = 0; l < LANES; l++) begin
        rem2 = {rem_i[l], num_i[l][DIV_N-1]};
        ge   = rem2 >= {1'b0, dvs_nxt[k]};
        rem_nxt[k][l] = ge ? DVS_W'(rem2 - {1'b0, dvs_nxt[k]}) : DVS_W'(rem2);
        num_nxt[k][l] = {num_i[l][DIV_N-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < DIV_N; k++) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_nxt[k];
      end
      if (en) begin
        dvs_r[k]  <= dvs_nxt[k];
        rem_r[k]  <= rem_nxt[k];
        num_r[k]  <= num_nxt[k];
        side_r[k] <= side_nxt[k];
      end
    end
  end

  assign out_vld  = vld_r[DIV_N-1];
  assign out_quo  = num_r[DIV_N-1];
  assign out_side = side_r[DIV_N-1];

endmodule

// ===== sv/rotation_matrix_to_quaternion_core.sv =====
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_core
// Converts a Q1.14 rotation matrix to a Q1.14 quaternion, fully pipelined.
// ----------------------------------------------------------------------------
// One word is accepted every cycle that in_ready is high, and each word's
// result reaches the output having passed 43 register stages: an input
// register, a branch/argument stage, a 16-stage square root (one root
// bit per stage), a 24-stage four-lane divider (one quotient bit per stage)
// and an output register. The whole pipe advances together whenever the
// output register is empty or being taken, so in_ready drops only while a
// result sits unclaimed at the output.
module rotation_matrix_to_quaternion_core import rmq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [Q_W-1:0] in_m00,
  input  logic signed [Q_W-1:0] in_m01,
  input  logic signed [Q_W-1:0] in_m02,
  input  logic signed [Q_W-1:0] in_m10,
  input  logic signed [Q_W-1:0] in_m11,
  input  logic signed [Q_W-1:0] in_m12,
  input  logic signed [Q_W-1:0] in_m20,
  input  logic signed [Q_W-1:0] in_m21,
  input  logic signed [Q_W-1:0] in_m22,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [Q_W-1:0] out_qw,
  output logic signed [Q_W-1:0] out_qx,
  output logic signed [Q_W-1:0] out_qy,
  output logic signed [Q_W-1:0] out_qz,
  output logic                  out_invalid
);

  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // input register
  logic in_vld_r;
  mat_t mat_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (adv) begin
      in_vld_r <= in_valid;
    end
    if (adv) begin
      mat_r <= {in_m22, in_m21, in_m20, in_m12, in_m11, in_m10, in_m02, in_m01, in_m00};
    end
  end

  // branch and argument
  logic             p_vld;
  logic [RAD_W-1:0] p_rad;
  side_t            p_side;
  rmq_prep u_prep (
    .clk(clk), .rst_n(rst_n), .en(adv), .in_vld(in_vld_r), .in_mat(mat_r),
    .out_vld(p_vld), .out_rad(p_rad), .out_side(p_side)
  );

  // square root
  logic              s_vld;
  logic [ROOT_W-1:0] s_root;
  side_t             s_side;
  rmq_isqrt u_isqrt (
    .clk(clk), .rst_n(rst_n), .en(adv), .in_vld(p_vld), .in_rad(p_rad),
    .in_side(p_side), .out_vld(s_vld), .out_root(s_root), .out_side(s_side)
  );

  // numerators, divisor and half root
  num4_t            d_num;
  dside_t           d_side;
  logic [ROOT_W:0]  hr_sum;
  always_comb begin
    logic signed [D_W-1:0] dv;
    logic [D_W-1:0]        mag;
    hr_sum       = {1'b0, s_root} + (ROOT_W+1)'(1);
    d_side.sel   = s_side.sel;
    d_side.bad   = s_side.bad;
    d_side.hr    = Q_W'(hr_sum[ROOT_W:1]);
    for (int l = 0; l < LANES; l++) begin
      dv            = $signed(s_side.d[l]);
      d_side.neg[l] = dv[D_W-1];
      mag           = dv[D_W-1] ? D_W'(-dv) : D_W'(dv);
      d_num[l]      = NUM_W'({mag[16:0], 14'b0}) + NUM_W'(s_root);
    end
  end

  logic   v_vld;
  quo4_t  v_quo;
  dside_t v_side;
  rmq_div u_div (
    .clk(clk), .rst_n(rst_n), .en(adv), .in_vld(s_vld), .in_num(d_num),
    .in_dvs({s_root, 1'b0}), .in_side(d_side),
    .out_vld(v_vld), .out_quo(v_quo), .out_side(v_side)
  );

  // sign, saturation, lane select
  logic [LANES-1:0][Q_W-1:0] q_nxt;
  logic [LANES-1:0][Q_W-1:0] q_r;
  logic                      out_valid_r, bad_r;
  always_comb begin
    logic [DIV_N-1:0] qv;
    for (int l = 0; l < LANES; l++) begin
      qv = v_quo[l];
      if (v_side.bad) begin
        q_nxt[l] = '0;
      end else if (lane_e'(l) == v_side.sel) begin
        q_nxt[l] = v_side.hr;
      end else if (v_side.neg[l]) begin
        q_nxt[l] = (qv > DIV_N'(32768)) ? 16'h8000 : Q_W'(DIV_N'(0) - qv);
      end else begin
        q_nxt[l] = (qv > DIV_N'(32767)) ? 16'h7fff : qv[Q_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= v_vld;
    end
    if (adv) begin
      q_r   <= q_nxt;
      bad_r <= v_side.bad;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_qw      = $signed(q_r[LANE_W]);
  assign out_qx      = $signed(q_r[LANE_X]);
  assign out_qy      = $signed(q_r[LANE_Y]);
  assign out_qz      = $signed(q_r[LANE_Z]);
  assign out_invalid = bad_r;

  // pipe moves whenever the output is free
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready) else $error("pipe stalled with empty output");

  // held output blocks intake
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !in_ready) else $error("intake during stall");

  // invalid result carries zero components
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_invalid) |->
      (out_qw == 0 && out_qx == 0 && out_qy == 0 && out_qz == 0))
    else $error("invalid result not zero");

endmodule
